FILE: design/cdsc_pkg.sv
package cdsc_pkg;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  // Both datapaths deliver their result from the same pipeline stage.
  localparam int NSTAGE    = 7;
  localparam int ENC_DEPTH = 4;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [17:0] DAYS_400Y  = 18'd146097;
  localparam logic [10:0] DAYS_4Y    = 11'd1461;
  localparam logic [19:0] SERIAL_BIAS = 20'd693900;

  localparam logic signed [24:0] SERIAL_LOW  = -25'sd693594;
  localparam logic signed [24:0] SERIAL_HIGH = 25'sd2958465;

  // Reciprocals for exact division by constants over the operand ranges used.
  localparam int          SH_100   = 19;
  localparam logic [12:0] RECIP_100 = 13'(((1 << SH_100) + 99) / 100);
  localparam int          SH_400Y  = 43;
  localparam logic [25:0] RECIP_400Y =
    26'(((64'd1 << SH_400Y) + 64'd146096) / 64'd146097);
  localparam int          SH_4Y    = 29;
  localparam logic [18:0] RECIP_4Y = 19'(((1 << SH_4Y) + 1460) / 1461);
  localparam int          SH_153   = 20;
  localparam logic [12:0] RECIP_153 = 13'(((1 << SH_153) + 152) / 153);

  // Days before the start of a month, with months counted from March as 0.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

FILE: design/cdsc_req_if.sv
interface cdsc_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [13:0]        year_in;
  logic [3:0]         month_in;
  logic [4:0]         day_in;
  logic signed [22:0] serial_in;

  modport source(output valid, command, year_in, month_in, day_in, serial_in,
                 input ready);
  modport sink(input valid, command, year_in, month_in, day_in, serial_in,
               output ready);
endinterface

FILE: design/cdsc_rsp_if.sv
interface cdsc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] serial_out;
  logic [13:0]        year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;
  logic               valid_res;

  modport source(output valid, serial_out, year_out, month_out, day_out, valid_res,
                 input ready);
  modport sink(input valid, serial_out, year_out, month_out, day_out, valid_res,
               output ready);
endinterface

FILE: design/calendar_date_serial_converter.sv
// Converts a Gregorian date to a day serial (day 0 is 1899-12-30) or a serial
// back to a date, one item per clock cycle sustained while the output is ready.
// The depth of the pipeline is set by the decode path, which takes three
// constant divisions (by 146097, 1461 and 153) as reciprocal multiplies,
// each in a stage of its own followed by the remainder step; the encode
// result is delayed to leave at the same stage. Back-pressure stalls only
// as far back as needed: a stage with no item in it keeps taking work while
// the result register waits to be taken.
module calendar_date_serial_converter import cdsc_pkg::*; (
  input logic        clk,
  input logic        rst,
  cdsc_req_if.sink   req,
  cdsc_rsp_if.source rsp
);

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   rdy;
  logic [NSTAGE:0]   vld_in;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[NSTAGE] = rsp.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vld_in = {vld, req.valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  logic [22:0] enc_serial;
  logic        enc_ok;
  logic [13:0] dec_year;
  logic [3:0]  dec_month;
  logic [4:0]  dec_day;
  logic        dec_ok;

  cdsc_enc u_enc (
    .clk      (clk),
    .en       (rdy[NSTAGE-1:0]),
    .command  (req.command),
    .year_in  (req.year_in),
    .month_in (req.month_in),
    .day_in   (req.day_in),
    .serial   (enc_serial),
    .ok       (enc_ok)
  );

  cdsc_dec u_dec (
    .clk       (clk),
    .en        (rdy[NSTAGE-1:0]),
    .command   (req.command),
    .serial_in (req.serial_in),
    .year      (dec_year),
    .month     (dec_month),
    .day       (dec_day),
    .ok        (dec_ok)
  );

  assign req.ready      = rdy[0];
  assign rsp.valid      = vld[NSTAGE-1];
  assign rsp.serial_out = enc_serial;
  assign rsp.year_out   = dec_year;
  assign rsp.month_out  = dec_month;
  assign rsp.day_out    = dec_day;
  assign rsp.valid_res  = enc_ok | dec_ok;

  // A rejected item carries an all-zero payload.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.valid_res |->
      rsp.serial_out == 23'd0 && rsp.year_out == 14'd0 &&
      rsp.month_out == 4'd0 && rsp.day_out == 5'd0)
    else $error("invalid result with nonzero payload");

  // A decoded date always has a real month and day.
  a_decoded_date: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.year_out != 14'd0 |->
      rsp.valid_res && rsp.month_out >= 4'd1 && rsp.month_out <= 4'd12 &&
      rsp.day_out >= 5'd1 && rsp.day_out <= 5'd31 && rsp.serial_out == 23'd0)
    else $error("decoded date out of range");

  // With the output side free, the pipeline never refuses an item.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    rsp.ready |-> req.ready)
    else $error("input stalled while output is ready");

  // An accepted item enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> vld[0])
    else $error("accepted item lost at entry");

endmodule

FILE: design/cdsc_enc.sv
module cdsc_enc import cdsc_pkg::*; (
  input  logic              clk,
  input  logic [NSTAGE-1:0] en,
  input  logic              command,
  input  logic [13:0]       year_in,
  input  logic [3:0]        month_in,
  input  logic [4:0]        day_in,
  output logic [22:0]       serial,
  output logic              ok
);

  // Stage 1: shift the year start to March and split off the century.
  logic        cmd1;
  logic [13:0] yr1, yadj1;
  logic [3:0]  mo1;
  logic [4:0]  dy1;
  logic [7:0]  craw1, cadj1;
  logic [13:0] yadj_w;
  logic [26:0] praw_w, padj_w;

  always_comb begin
    yadj_w = (month_in > 4'd2) ? year_in : year_in - 14'd1;
    praw_w = 27'(year_in) * 27'(RECIP_100);
    padj_w = 27'(yadj_w) * 27'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd1  <= command;
      yr1   <= year_in;
      mo1   <= month_in;
      dy1   <= day_in;
      yadj1 <= yadj_w;
      craw1 <= padj_w[26:19] ^ padj_w[26:19] ^ praw_w[26:19];
      cadj1 <= padj_w[26:19];
    end
  end

  // Stage 2: leap rule, range checks and the year within the century.
  logic       ok2;
  logic [6:0] c2, ya2;
  logic [3:0] madj2;
  logic [4:0] dy2;
  logic       leap_w, ok_w;
  logic [13:0] ya_w;

  always_comb begin
    leap_w = (yr1[1:0] == 2'b00) &&
             ((yr1 != 14'(craw1) * 14'd100) || (craw1[1:0] == 2'b00));
    ok_w   = (cmd1 == CMD_ENCODE) && (yr1 >= 14'd1) && (yr1 <= YEAR_MAX) &&
             (mo1 >= 4'd1) && (mo1 <= MONTH_MAX) && (dy1 >= 5'd1) &&
             (dy1 <= month_days(mo1, leap_w));
    ya_w   = yadj1 - 14'(cadj1) * 14'd100;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok2   <= ok_w;
      c2    <= cadj1[6:0];
      ya2   <= ya_w[6:0];
      madj2 <= (mo1 > 4'd2) ? mo1 - 4'd3 : mo1 + 4'd9;
      dy2   <= dy1;
    end
  end

  // Stage 3: day counts of whole centuries, whole years and whole months.
  logic        ok3;
  logic [21:0] pa3;
  logic [15:0] pb3;
  logic [8:0]  mt3;
  logic [4:0]  dy3;
  logic [23:0] pa_w;
  logic [17:0] pb_w;

  always_comb begin
    pa_w = 24'(c2) * 24'(DAYS_400Y);
    pb_w = 18'(ya2) * 18'(DAYS_4Y);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ok3 <= ok2;
      pa3 <= pa_w[23:2];
      pb3 <= pb_w[17:2];
      mt3 <= cum_days(madj2);
      dy3 <= dy2;
    end
  end

  // Stage 4: final sum, then delay taps up to the output stage.
  logic [22:0] ser_q [ENC_DEPTH-1:NSTAGE-1];
  logic        ok_q  [ENC_DEPTH-1:NSTAGE-1];
  logic [23:0] sum_w;

  always_comb begin
    sum_w = 24'(pa3) + 24'(pb3) + 24'(mt3) + 24'(dy3) - 24'(SERIAL_BIAS);
  end

  always_ff @(posedge clk) begin
    if (en[ENC_DEPTH-1]) begin
      ok_q[ENC_DEPTH-1]  <= ok3;
      ser_q[ENC_DEPTH-1] <= ok3 ? sum_w[22:0] : 23'd0;
    end
    for (int k = ENC_DEPTH; k < NSTAGE; k++) begin
      if (en[k]) begin
        ok_q[k]  <= ok_q[k-1];
        ser_q[k] <= ser_q[k-1];
      end
    end
  end

  assign serial = ser_q[NSTAGE-1];
  assign ok     = ok_q[NSTAGE-1];

endmodule

FILE: design/cdsc_dec.sv
module cdsc_dec import cdsc_pkg::*; (
  input  logic               clk,
  input  logic [NSTAGE-1:0]  en,
  input  logic               command,
  input  logic signed [22:0] serial_in,
  output logic [13:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic               ok
);

  // Stage 1: range check, clamp and bias to a day count from March of year 0.
  logic               ok1;
  logic [23:0]        j1;
  logic signed [24:0] s_w, sc_w, n_w;

  always_comb begin
    s_w  = {{2{serial_in[22]}}, serial_in};
    sc_w = (s_w > SERIAL_HIGH) ? SERIAL_HIGH : s_w;
    n_w  = sc_w + 25'(SERIAL_BIAS);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok1 <= (command == CMD_DECODE) && (s_w > SERIAL_LOW);
      j1  <= {n_w[21:0], 2'b00} - 24'd1;
    end
  end

  // Stage 2: number of whole 400-year cycles, as centuries.
  logic        ok2;
  logic [23:0] j2;
  logic [6:0]  ly2;
  logic [49:0] p400_w;

  assign p400_w = 50'(j1) * 50'(RECIP_400Y);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok2 <= ok1;
      j2  <= j1;
      ly2 <= p400_w[49:43];
    end
  end

  // Stage 3: remainder within the century.
  logic        ok3;
  logic [6:0]  ly3;
  logic [17:0] x3;
  logic [23:0] r_w;

  assign r_w = j2 - 24'(ly2) * 24'(DAYS_400Y);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ok3 <= ok2;
      ly3 <= ly2;
      x3  <= {r_w[17:2], 2'b11};
    end
  end

  // Stage 4: year within the century.
  logic        ok4;
  logic [6:0]  ly4, yc4;
  logic [17:0] x4;
  logic [36:0] p4y_w;

  assign p4y_w = 37'(x3) * 37'(RECIP_4Y);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ok4 <= ok3;
      ly4 <= ly3;
      x4  <= x3;
      yc4 <= p4y_w[35:29];
    end
  end

  // Stage 5: day of the March-based year, counted from 1.
  logic        ok5;
  logic [6:0]  ly5, yc5;
  logic [8:0]  ld5;
  logic [10:0] v5;
  logic [17:0] t_w;
  logic [8:0]  ld_w;

  always_comb begin
    t_w  = x4 + 18'd4 - 18'(yc4) * 18'(DAYS_4Y);
    ld_w = t_w[10:2];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ok5 <= ok4;
      ly5 <= ly4;
      yc5 <= yc4;
      ld5 <= ld_w;
      v5  <= 11'(ld_w) * 11'd5 - 11'd3;
    end
  end

  // Stage 6: March-based month.
  logic        ok6;
  logic [6:0]  ly6, yc6;
  logic [8:0]  ld6;
  logic [3:0]  lm6;
  logic [23:0] p153_w;

  assign p153_w = 24'(v5) * 24'(RECIP_153);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      ok6 <= ok5;
      ly6 <= ly5;
      yc6 <= yc5;
      ld6 <= ld5;
      lm6 <= p153_w[23:20];
    end
  end

  // Stage 7: day of month from the month start table, back to a January year.
  logic        ok7;
  logic [13:0] yr7;
  logic [3:0]  mo7;
  logic [4:0]  dy7;
  logic        wrap_w;
  logic [8:0]  dd_w;

  always_comb begin
    wrap_w = (lm6 >= 4'd10);
    dd_w   = ld6 - cum_days(lm6);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      ok7 <= ok6;
      yr7 <= ok6 ? 14'(ly6) * 14'd100 + 14'(yc6) + 14'(wrap_w) : 14'd0;
      mo7 <= ok6 ? (wrap_w ? lm6 - 4'd9 : lm6 + 4'd3) : 4'd0;
      dy7 <= ok6 ? dd_w[4:0] : 5'd0;
    end
  end

  assign year  = yr7;
  assign month = mo7;
  assign day   = dy7;
  assign ok    = ok7;

endmodule
